// ===== design/tobb_pkg.sv =====
// ---------------------------------------------------------------------------
// tobb_pkg
// Shared types and constants of the tile opaque bounding box unit.
// ---------------------------------------------------------------------------
package tobb_pkg;

    localparam int MAX_DIM       = 4096;
    localparam int PIXEL_BYTES   = 4;
    localparam int BITS_PER_BYTE = 8;

    // counter holds 0..MAX_DIM-1, dimension holds 1..MAX_DIM
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DIM_W = 13;
    localparam int POS_W = 16;
    localparam int PIX_W = 32;

    localparam logic [PIX_W-1:0] PIX_MASK =
        PIX_W'((64'd1 << (BITS_PER_BYTE * PIXEL_BYTES)) - 64'd1);

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    // apb register map
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int DATA_W    = 32;

    localparam logic [REG_IDX_W-1:0] REG_TILE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TILE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TILE_X      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TILE_Y      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HANDLE_X    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HANDLE_Y    = 3'd5;

    typedef struct packed {
        logic        [DIM_W-1:0] tile_width;
        logic        [DIM_W-1:0] tile_height;
        logic        [POS_W-1:0] tile_x;
        logic        [POS_W-1:0] tile_y;
        logic signed [POS_W-1:0] handle_x;
        logic signed [POS_W-1:0] handle_y;
    } t_cfg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/tobb_ifs.sv =====
// ---------------------------------------------------------------------------
// tobb interfaces
// Pixel input channel and bounding box result channel, valid/ready.
// ---------------------------------------------------------------------------
interface tobb_pix_if
    import tobb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface tobb_box_if
    import tobb_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic        [POS_W-1:0] new_x;
    logic        [POS_W-1:0] new_y;
    logic        [DIM_W-1:0] new_width;
    logic        [DIM_W-1:0] new_height;
    logic signed [POS_W-1:0] new_handle_x;
    logic signed [POS_W-1:0] new_handle_y;

    modport source (output valid, output new_x, output new_y, output new_width,
                    output new_height, output new_handle_x, output new_handle_y,
                    input ready);
    modport sink   (input valid, input new_x, input new_y, input new_width,
                    input new_height, input new_handle_x, input new_handle_y,
                    output ready);
endinterface

// ===== design/tobb_regs.sv =====
// ---------------------------------------------------------------------------
// tobb_regs
// APB configuration registers: tile size, tile position and handle.
// ---------------------------------------------------------------------------
module tobb_regs
    import tobb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tile_width  <= DIM_W'(1);
            r_cfg.tile_height <= DIM_W'(1);
            r_cfg.tile_x      <= '0;
            r_cfg.tile_y      <= '0;
            r_cfg.handle_x    <= '0;
            r_cfg.handle_y    <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_TILE_WIDTH:  r_cfg.tile_width  <= pwdata[DIM_W-1:0];
                REG_TILE_HEIGHT: r_cfg.tile_height <= pwdata[DIM_W-1:0];
                REG_TILE_X:      r_cfg.tile_x      <= pwdata[POS_W-1:0];
                REG_TILE_Y:      r_cfg.tile_y      <= pwdata[POS_W-1:0];
                REG_HANDLE_X:    r_cfg.handle_x    <= $signed(pwdata[POS_W-1:0]);
                REG_HANDLE_Y:    r_cfg.handle_y    <= $signed(pwdata[POS_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TILE_WIDTH:  prdata = DATA_W'(r_cfg.tile_width);
            REG_TILE_HEIGHT: prdata = DATA_W'(r_cfg.tile_height);
            REG_TILE_X:      prdata = DATA_W'(r_cfg.tile_x);
            REG_TILE_Y:      prdata = DATA_W'(r_cfg.tile_y);
            REG_HANDLE_X:    prdata = DATA_W'($unsigned(r_cfg.handle_x));
            REG_HANDLE_Y:    prdata = DATA_W'($unsigned(r_cfg.handle_y));
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/tobb_track.sv =====
// ---------------------------------------------------------------------------
// tobb_track
// Input register, bounding box tracking and result register.
// ---------------------------------------------------------------------------
module tobb_track
    import tobb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    tobb_pix_if.sink   i_pix,
    tobb_box_if.source o_box
);

    // input stage
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pixel;

    // tracking state
    logic [CNT_W-1:0] r_col, r_row;
    logic [CNT_W-1:0] r_min_c, r_max_c, r_min_r, r_max_r;
    logic             r_any;

    // result register
    logic                    r_out_valid;
    logic        [POS_W-1:0] r_new_x, r_new_y;
    logic        [DIM_W-1:0] r_new_w, r_new_h;
    logic signed [POS_W-1:0] r_new_hx, r_new_hy;

    logic             opaque, row_end, tile_end, advance;
    logic [DIM_W-1:0] w, h;
    logic [CNT_W-1:0] n_min_c, n_max_c, n_min_r, n_max_r;
    logic             n_any;

    assign w        = clamp_dim(i_cfg.tile_width);
    assign h        = clamp_dim(i_cfg.tile_height);
    assign opaque   = (r_s1_pixel & PIX_MASK) != '0;
    assign row_end  = ({1'b0, r_col} + DIM_W'(1)) >= w;
    assign tile_end = row_end && (({1'b0, r_row} + DIM_W'(1)) >= h);

    // only the last pixel of a tile needs the result register
    assign advance     = r_s1_valid && (!tile_end || !r_out_valid || o_box.ready);
    assign i_pix.ready = !r_s1_valid || advance;

    always_comb begin
        n_min_c = (opaque && r_col < r_min_c) ? r_col : r_min_c;
        n_max_c = (opaque && r_col > r_max_c) ? r_col : r_max_c;
        n_min_r = (opaque && r_row < r_min_r) ? r_row : r_min_r;
        n_max_r = (opaque && r_row > r_max_r) ? r_row : r_max_r;
        n_any   = r_any || opaque;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= i_pix.valid;
        end
        if (i_pix.ready && i_pix.valid) begin
            r_s1_pixel <= i_pix.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_min_c <= '1;
            r_max_c <= '0;
            r_min_r <= '1;
            r_max_r <= '0;
            r_any   <= 1'b0;
        end else if (advance) begin
            if (tile_end) begin
                r_col   <= '0;
                r_row   <= '0;
                r_min_c <= '1;
                r_max_c <= '0;
                r_min_r <= '1;
                r_max_r <= '0;
                r_any   <= 1'b0;
            end else begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + CNT_W'(1);
                end else begin
                    r_col <= r_col + CNT_W'(1);
                end
                r_min_c <= n_min_c;
                r_max_c <= n_max_c;
                r_min_r <= n_min_r;
                r_max_r <= n_max_r;
                r_any   <= n_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && tile_end) begin
            r_out_valid <= 1'b1;
        end else if (o_box.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && tile_end) begin
            if (n_any) begin
                r_new_x  <= i_cfg.tile_x + POS_W'(n_min_c);
                r_new_y  <= i_cfg.tile_y + POS_W'(n_min_r);
                r_new_w  <= {1'b0, n_max_c} - {1'b0, n_min_c} + DIM_W'(1);
                r_new_h  <= {1'b0, n_max_r} - {1'b0, n_min_r} + DIM_W'(1);
                r_new_hx <= i_cfg.handle_x + $signed(POS_W'(n_min_c));
                r_new_hy <= i_cfg.handle_y + $signed(POS_W'(n_min_r));
            end else begin
                r_new_x  <= i_cfg.tile_x;
                r_new_y  <= i_cfg.tile_y;
                r_new_w  <= '0;
                r_new_h  <= '0;
                r_new_hx <= i_cfg.handle_x;
                r_new_hy <= i_cfg.handle_y;
            end
        end
    end

    assign o_box.valid        = r_out_valid;
    assign o_box.new_x        = r_new_x;
    assign o_box.new_y        = r_new_y;
    assign o_box.new_width    = r_new_w;
    assign o_box.new_height   = r_new_h;
    assign o_box.new_handle_x = r_new_hx;
    assign o_box.new_handle_y = r_new_hy;

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_min_c <= r_max_c) && (r_min_r <= r_max_r))
        else $error("tracked box has min above max");

    a_clear_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any |-> (r_min_c == '1) && (r_max_c == '0) && (r_min_r == '1) && (r_max_r == '0))
        else $error("box state not clear with no opaque pixel");

    a_restart_after_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && tile_end |=> (r_col == '0) && (r_row == '0) && !r_any)
        else $error("counters not restarted after tile end");

    a_result_from_tile_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && tile_end))
        else $error("result without a tile end");

endmodule

// ===== design/tile_opaque_bounding_box_unit.sv =====
// ---------------------------------------------------------------------------
// tile_opaque_bounding_box_unit
// Shrinks a tile to the bounding box of its non-transparent pixels.
// ---------------------------------------------------------------------------
// Usage:
//   Program tile size, tile position and handle over the APB port (words at
//   0x00..0x14), then stream the tile's pixels in raster order on i_pix, one
//   32-bit pixel per transfer. A pixel is transparent only if it is all zero.
//   After the last pixel of the tile one result transfer appears on o_box:
//   new position, bounding box size and shifted handle; an all clear tile
//   returns size zero and the programmed position and handle.
// Timing:
//   one pixel per cycle sustained while no result waits on o_box (see Stall).
//   A pixel passes an input register and, on the last pixel of a tile, the
//   result register, which drives the result transfer on o_box.
// Stall:
//   while a result waits on o_box the input register still takes a pixel
//   and the tracker keeps working; only the last pixel of the next tile
//   waits until the result register is free.
// Reset:
//   synchronous, active low; registers return to width 1, height 1, zero
//   position and handle, and the tile restarts at row 0, column 0.
// ---------------------------------------------------------------------------
module tile_opaque_bounding_box_unit
    import tobb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    tobb_pix_if.sink          i_pix,
    tobb_box_if.source        o_box
);

    t_cfg cfg;

    tobb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tobb_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (i_pix),
        .o_box   (o_box)
    );

endmodule
